### design/wsta_pkg.sv
// shared types and constants of the waypoint segment time allocator
`default_nettype none

package wsta_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// configuration register indexes
	localparam logic [1:0] REG_MAX_VEL  = 2'd0;
	localparam logic [1:0] REG_MAX_ACC  = 2'd1;
	localparam logic [1:0] REG_MODE     = 2'd2;
	localparam logic [1:0] REG_MIN_TIME = 2'd3;

	// profile modes
	localparam logic [1:0] MODE_SYM = 2'd0;
	localparam logic [1:0] MODE_ACC = 2'd1;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_MX,
		DP_MY,
		DP_MZ,
		DP_SQ1,
		DP_SQ_STEP,
		DP_MDA,
		DP_MVV,
		DP_CMP,
		DP_MAV,
		DP_DIV_INIT,
		DP_DIV_STEP,
		DP_SQ2,
		DP_FIN
	} dp_op_t;

	typedef struct packed {
		logic step_last;
		logic accel;
		logic cruise;
		logic div_zero;
	} dp_status_t;

endpackage

`default_nettype wire

### design/wsta_dp.sv
// datapath: waypoint store, multiplier, shared root unit and divider, output register
`default_nettype none

module wsta_dp #(
	parameter int FRAC_BITS = wsta_pkg::FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire wsta_pkg::dp_op_t    op,
	output wsta_pkg::dp_status_t     status,
	input  wire logic                cfg_write,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [31:0]         cfg_data,
	input  wire logic signed [31:0]  x_pos,
	input  wire logic signed [31:0]  y_pos,
	input  wire logic signed [31:0]  z_pos,
	input  wire logic                last_point,
	output logic [31:0]              segment_time,
	output logic                     last_segment,
	output logic                     saturated
);

	localparam int NUM_W  = (68 + FRAC_BITS > 35 + 2 * FRAC_BITS) ?
		68 + FRAC_BITS : 35 + 2 * FRAC_BITS;
	localparam int RAD_W  = NUM_W + (NUM_W % 2);
	localparam int ROOT_W = RAD_W / 2;
	localparam int DEN_W  = 65;
	localparam int CNT_W  = $clog2(NUM_W + 1);
	localparam logic [31:0] VEL_RST = 32'(64'd4 << FRAC_BITS);
	localparam logic [31:0] ACC_RST = 32'(64'd4 << FRAC_BITS);
	localparam logic [31:0] MIN_RST = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

	logic [31:0] vel_q, amax_q, tmin_q;
	logic [1:0]  mode_q;
	logic [31:0] prev_x_q, prev_y_q, prev_z_q;
	logic [32:0] ex_q, ey_q, ez_q;
	logic        last_q;
	logic [65:0] prod_q, sum_q;
	logic [32:0] d_q;
	logic [66:0] pda_q;
	logic [63:0] vv_q;
	logic        cruise_q, zero_q, sel_root_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+1:0] srem_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q, drem_q;
	logic [CNT_W-1:0]  cnt_q;

	logic        accel, zero, acc_mode;
	logic [32:0] dx, dy, dz;
	logic [32:0] mul_a, mul_b;
	logic [ROOT_W+3:0] s_part, s_trial;
	logic        s_ge;
	logic [DEN_W:0] d_part;
	logic        d_ge;
	logic [67:0] cruise_num;
	logic [NUM_W-1:0] fin_val;
	logic        fin_sat;
	logic [31:0] fin_t;

	function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		d = {a[31], a} - {b[31], b};
		return d[32] ? 33'(-d) : d;
	endfunction

	assign accel    = (mode_q == wsta_pkg::MODE_SYM) || (mode_q == wsta_pkg::MODE_ACC);
	assign acc_mode = (mode_q == wsta_pkg::MODE_ACC);
	assign zero     = (vel_q == 32'd0) || (accel && (amax_q == 32'd0));

	assign dx = abs_diff(x_pos, prev_x_q);
	assign dy = abs_diff(y_pos, prev_y_q);
	assign dz = abs_diff(z_pos, prev_z_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			wsta_pkg::DP_MX: begin
				mul_a = ex_q;
				mul_b = ex_q;
			end
			wsta_pkg::DP_MY: begin
				mul_a = ey_q;
				mul_b = ey_q;
			end
			wsta_pkg::DP_MZ: begin
				mul_a = ez_q;
				mul_b = ez_q;
			end
			wsta_pkg::DP_MDA: begin
				mul_a = root_q[32:0];
				mul_b = {1'b0, amax_q};
			end
			wsta_pkg::DP_MVV: begin
				mul_a = {1'b0, vel_q};
				mul_b = {1'b0, vel_q};
			end
			wsta_pkg::DP_MAV: begin
				mul_a = {1'b0, amax_q};
				mul_b = {1'b0, vel_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// root step: two radicand bits per cycle
	assign s_part  = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign s_trial = (ROOT_W + 4)'({root_q, 2'b01});
	assign s_ge    = s_part >= s_trial;

	// restoring division step: one quotient bit per cycle
	assign d_part = {drem_q, num_q[NUM_W-1]};
	assign d_ge   = d_part >= {1'b0, den_q};

	assign cruise_num = {4'd0, vv_q} + {1'b0, pda_q};

	always_comb begin
		fin_val = sel_root_q ? NUM_W'(root_q) : num_q;
		fin_sat = zero_q || (|fin_val[NUM_W-1:32]);
		fin_t   = fin_sat ? 32'hFFFF_FFFF : fin_val[31:0];
		if (fin_t < tmin_q) begin
			fin_t = tmin_q;
		end
	end

	assign status.step_last = (cnt_q == CNT_W'(1));
	assign status.accel     = accel;
	assign status.cruise    = cruise_q;
	assign status.div_zero  = zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_q  <= VEL_RST;
			amax_q <= ACC_RST;
			mode_q <= wsta_pkg::MODE_SYM;
			tmin_q <= MIN_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				wsta_pkg::REG_MAX_VEL:  vel_q  <= cfg_data;
				wsta_pkg::REG_MAX_ACC:  amax_q <= cfg_data;
				wsta_pkg::REG_MODE:     mode_q <= cfg_data[1:0];
				wsta_pkg::REG_MIN_TIME: tmin_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= {33'd0, mul_a} * {33'd0, mul_b};
		case (op)
			wsta_pkg::DP_LOAD: begin
				ex_q     <= dx;
				ey_q     <= dy;
				ez_q     <= dz;
				prev_x_q <= x_pos;
				prev_y_q <= y_pos;
				prev_z_q <= z_pos;
				last_q   <= last_point;
			end
			wsta_pkg::DP_MY: sum_q <= prod_q;
			wsta_pkg::DP_MZ: sum_q <= sum_q + prod_q;
			wsta_pkg::DP_SQ1: begin
				rad_q  <= RAD_W'(sum_q + prod_q);
				root_q <= '0;
				srem_q <= '0;
				cnt_q  <= CNT_W'(ROOT_W);
			end
			wsta_pkg::DP_SQ2: begin
				rad_q      <= RAD_W'(num_q);
				root_q     <= '0;
				srem_q     <= '0;
				cnt_q      <= CNT_W'(ROOT_W);
				sel_root_q <= 1'b1;
			end
			wsta_pkg::DP_SQ_STEP: begin
				srem_q <= s_ge ? (ROOT_W + 2)'(s_part - s_trial) : (ROOT_W + 2)'(s_part);
				root_q <= {root_q[ROOT_W-2:0], s_ge};
				rad_q  <= rad_q << 2;
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			wsta_pkg::DP_MDA: d_q <= root_q[32:0];
			wsta_pkg::DP_MVV: pda_q <= 67'(prod_q) << acc_mode;
			wsta_pkg::DP_CMP: begin
				vv_q     <= prod_q[63:0];
				cruise_q <= pda_q >= 67'(prod_q);
			end
			wsta_pkg::DP_DIV_INIT: begin
				zero_q     <= zero;
				sel_root_q <= 1'b0;
				drem_q     <= '0;
				cnt_q      <= CNT_W'(NUM_W);
				if (!accel) begin
					num_q <= NUM_W'(d_q) << FRAC_BITS;
					den_q <= DEN_W'(vel_q);
				end else if (cruise_q) begin
					num_q <= NUM_W'(cruise_num) << FRAC_BITS;
					den_q <= DEN_W'(prod_q) << acc_mode;
				end else begin
					num_q <= acc_mode ? (NUM_W'(d_q) << (2 * FRAC_BITS)) :
						(NUM_W'(d_q) << (2 * FRAC_BITS + 2));
					den_q <= DEN_W'(amax_q);
				end
			end
			wsta_pkg::DP_DIV_STEP: begin
				drem_q <= d_ge ? DEN_W'(d_part - {1'b0, den_q}) : d_part[DEN_W-1:0];
				num_q  <= {num_q[NUM_W-2:0], d_ge};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			wsta_pkg::DP_FIN: begin
				segment_time <= fin_t;
				saturated    <= fin_sat;
				last_segment <= last_q;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### design/wsta_ctrl.sv
// controller: sequences the datapath operations and runs both handshakes
`default_nettype none

module wsta_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wp_valid,
	output logic                      wp_ready,
	input  wire logic                 first_point,
	input  wire logic                 last_point,
	output logic                      seg_valid,
	input  wire logic                 seg_ready,
	output wsta_pkg::dp_op_t          op,
	input  wire wsta_pkg::dp_status_t status
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MX,
		S_MY,
		S_MZ,
		S_SQ1,
		S_ROOT1,
		S_MDA,
		S_MVV,
		S_CMP,
		S_MAV,
		S_DIVI,
		S_DIV,
		S_SQ2,
		S_ROOT2,
		S_FIN
	} state_t;

	state_t state_q;
	logic   have_prev_q;
	logic   seg_valid_q;
	logic   fin_go;

	assign wp_ready  = (state_q == S_IDLE);
	assign seg_valid = seg_valid_q;
	assign fin_go    = !seg_valid_q || seg_ready;

	always_comb begin
		case (state_q)
			S_IDLE:  op = wp_valid ? wsta_pkg::DP_LOAD : wsta_pkg::DP_NONE;
			S_MX:    op = wsta_pkg::DP_MX;
			S_MY:    op = wsta_pkg::DP_MY;
			S_MZ:    op = wsta_pkg::DP_MZ;
			S_SQ1:   op = wsta_pkg::DP_SQ1;
			S_ROOT1: op = wsta_pkg::DP_SQ_STEP;
			S_MDA:   op = wsta_pkg::DP_MDA;
			S_MVV:   op = wsta_pkg::DP_MVV;
			S_CMP:   op = wsta_pkg::DP_CMP;
			S_MAV:   op = wsta_pkg::DP_MAV;
			S_DIVI:  op = wsta_pkg::DP_DIV_INIT;
			S_DIV:   op = wsta_pkg::DP_DIV_STEP;
			S_SQ2:   op = wsta_pkg::DP_SQ2;
			S_ROOT2: op = wsta_pkg::DP_SQ_STEP;
			S_FIN:   op = fin_go ? wsta_pkg::DP_FIN : wsta_pkg::DP_NONE;
			default: op = wsta_pkg::DP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			have_prev_q <= 1'b0;
			seg_valid_q <= 1'b0;
		end else begin
			// a new word may load in the cycle the old one is taken
			if (state_q == S_FIN && fin_go) begin
				seg_valid_q <= 1'b1;
			end else if (seg_valid_q && seg_ready) begin
				seg_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (wp_valid) begin
						have_prev_q <= !last_point;
						// a word with no stored predecessor only starts a path
						state_q <= (have_prev_q && !first_point) ? S_MX : S_IDLE;
					end
				end
				S_MX:    state_q <= S_MY;
				S_MY:    state_q <= S_MZ;
				S_MZ:    state_q <= S_SQ1;
				S_SQ1:   state_q <= S_ROOT1;
				S_ROOT1: begin
					if (status.step_last) begin
						state_q <= S_MDA;
					end
				end
				S_MDA:   state_q <= S_MVV;
				S_MVV:   state_q <= S_CMP;
				S_CMP:   state_q <= status.accel ? S_MAV : S_DIVI;
				S_MAV:   state_q <= S_DIVI;
				S_DIVI:  state_q <= status.div_zero ? S_FIN : S_DIV;
				S_DIV: begin
					if (status.step_last) begin
						state_q <= (status.accel && !status.cruise) ? S_SQ2 : S_FIN;
					end
				end
				S_SQ2:   state_q <= S_ROOT2;
				S_ROOT2: begin
					if (status.step_last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/waypoint_segment_time_allocator.sv
// Waypoint segment time allocator. Each accepted waypoint word is compared with the
// stored previous waypoint; the Euclidean distance is turned into a segment time
// (symmetric trapezoid, accelerate-only or constant velocity profile), clamped below
// by min_segment_time and saturated at full scale, all in unsigned fixed point with
// FRAC_BITS fraction bits. One waypoint is worked on at a time. The shared root unit
// (two radicand bits per cycle) takes the distance root and, on the short-distance
// path, the time root; the restoring divider (one quotient bit per cycle) is skipped
// when a divisor is zero. A waypoint that yields no segment is only stored.
// A finished segment word waits in the output register while the next waypoint is
// accepted. Configuration must be written only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module waypoint_segment_time_allocator #(
	parameter int FRAC_BITS = wsta_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               wp_valid,
	output logic                    wp_ready,
	input  wire logic signed [31:0] x_pos,
	input  wire logic signed [31:0] y_pos,
	input  wire logic signed [31:0] z_pos,
	input  wire logic               first_point,
	input  wire logic               last_point,
	output logic                    seg_valid,
	input  wire logic               seg_ready,
	output logic [31:0]             segment_time,
	output logic                    last_segment,
	output logic                    saturated
);

	wsta_pkg::dp_op_t     op;
	wsta_pkg::dp_status_t status;

	wsta_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.wp_valid    (wp_valid),
		.wp_ready    (wp_ready),
		.first_point (first_point),
		.last_point  (last_point),
		.seg_valid   (seg_valid),
		.seg_ready   (seg_ready),
		.op          (op),
		.status      (status)
	);

	wsta_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.status       (status),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.z_pos        (z_pos),
		.last_point   (last_point),
		.segment_time (segment_time),
		.last_segment (last_segment),
		.saturated    (saturated)
	);

endmodule

`default_nettype wire

### tb/sv/wsta_segment_checker.sv
// segment time checker: watches the waypoint and segment channels, predicts and compares
`timescale 1ns / 1ps
`default_nettype none

module wsta_segment_checker #(
	parameter int FRAC = wsta_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        wp_valid,
	input  wire logic        wp_ready,
	input  wire logic [31:0] x_pos,
	input  wire logic [31:0] y_pos,
	input  wire logic [31:0] z_pos,
	input  wire logic        first_point,
	input  wire logic        last_point,
	input  wire logic        seg_valid,
	input  wire logic        seg_ready,
	input  wire logic [31:0] segment_time,
	input  wire logic        last_segment,
	input  wire logic        saturated,
	output int               fail_count,
	output int               segs_pending
);

	typedef struct packed {
		logic [31:0] seg_time;
		logic        seg_last;
		logic        seg_sat;
	} seg_word_t;

	logic [31:0] vel, acc, tmin;
	logic [1:0]  mode;
	logic [31:0] px, py, pz;
	logic        have_pt;
	seg_word_t   seg_q[$];

	function automatic logic [63:0] root_floor(input logic [127:0] s);
		logic [63:0]  r;
		logic [63:0]  t;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if ({64'd0, t} * {64'd0, t} <= s)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [31:0] abs_delta(input logic [31:0] p, input logic [31:0] q);
		logic signed [33:0] dd;
		dd = $signed({{2{p[31]}}, p}) - $signed({{2{q[31]}}, q});
		if (dd < 0)
			dd = -dd;
		return dd[31:0];
	endfunction

	function automatic seg_word_t segment_of(input logic [31:0] ex, input logic [31:0] ey,
			input logic [31:0] ez, input logic lst);
		logic [127:0] s, d, q, v, a, k;
		seg_word_t    w;
		s = {96'd0, ex} * {96'd0, ex} + {96'd0, ey} * {96'd0, ey}
			+ {96'd0, ez} * {96'd0, ez};
		d = {64'd0, root_floor(s)};
		v = {96'd0, vel};
		a = {96'd0, acc};
		if (mode == wsta_pkg::MODE_SYM || mode == wsta_pkg::MODE_ACC) begin
			k = (mode == wsta_pkg::MODE_SYM) ? 128'd1 : 128'd2;
			if (vel == 0 || acc == 0)
				q = 128'd1 << 64;
			else if (d * k * a < v * v)
				q = {64'd0, root_floor((d << (mode == wsta_pkg::MODE_SYM ?
					2 * FRAC + 2 : 2 * FRAC)) / a)};
			else
				q = ((v * v + d * k * a) << FRAC) / (k * a * v);
		end else begin
			// unused selector falls back to constant velocity
			if (vel == 0)
				q = 128'd1 << 64;
			else
				q = (d << FRAC) / v;
		end
		w.seg_sat = (q > 128'hFFFF_FFFF);
		w.seg_time = w.seg_sat ? 32'hFFFF_FFFF : q[31:0];
		if (w.seg_time < tmin)
			w.seg_time = tmin;
		w.seg_last = lst;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		seg_word_t e;
		if (!arst_n) begin
			vel <= 32'd4 << FRAC;
			acc <= 32'd4 << FRAC;
			mode <= wsta_pkg::MODE_SYM;
			tmin <= ((32'd1 << FRAC) + 5) / 10;
			have_pt <= 1'b0;
			px <= '0;
			py <= '0;
			pz <= '0;
			fail_count <= 0;
			segs_pending <= 0;
			seg_q.delete();
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					wsta_pkg::REG_MAX_VEL: vel <= cfg_data;
					wsta_pkg::REG_MAX_ACC: acc <= cfg_data;
					wsta_pkg::REG_MODE: mode <= cfg_data[1:0];
					wsta_pkg::REG_MIN_TIME: tmin <= cfg_data;
					default: ;
				endcase
			end
			if (wp_valid && wp_ready) begin
				if (have_pt && !first_point)
					seg_q.insert(seg_q.size(), segment_of(abs_delta(x_pos, px),
						abs_delta(y_pos, py), abs_delta(z_pos, pz), last_point));
				px <= x_pos;
				py <= y_pos;
				pz <= z_pos;
				have_pt <= !last_point;
			end
			if (seg_valid && seg_ready) begin
				if (seg_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected segment word: time %h last %b sat %b",
							segment_time, last_segment, saturated);
					fail_count <= fail_count + 1;
				end else begin
					e = seg_q.pop_front();
					if (e.seg_time !== segment_time || e.seg_last !== last_segment
							|| e.seg_sat !== saturated) begin
						if (fail_count < 10)
							$display("segment mismatch: exp time %h last %b sat %b, got %h %b %b",
								e.seg_time, e.seg_last, e.seg_sat,
								segment_time, last_segment, saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
			segs_pending <= seg_q.size();
		end
	end

endmodule

`default_nettype wire

### tb/sv/tb_waypoint_segment_time_allocator.sv
// testbench top: waypoint stimulus, configuration phases and verdict
`timescale 1ns / 1ps
`default_nettype none

module tb_waypoint_segment_time_allocator;

	localparam logic [1:0] MODE_CONST = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int IDLE_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 250;

	logic        clk, arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        wp_valid, wp_ready;
	logic signed [31:0] x_pos, y_pos, z_pos;
	logic        first_point, last_point;
	logic        seg_valid, seg_ready;
	logic [31:0] segment_time;
	logic        last_segment, saturated;
	int          fail_count, segs_pending;
	int          idle_cycles = 0;
	int          burst_left;
	int          stall_style = 0;
	logic signed [31:0] bx, by, bz;

	waypoint_segment_time_allocator dut (.*);

	wsta_segment_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: stall style changes now and then
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0)
			stall_style = $urandom_range(0, 3);
		case (stall_style)
			0: seg_ready <= 1'b1;
			1: seg_ready <= ($urandom_range(0, 3) != 0);
			2: seg_ready <= ($urandom_range(0, 3) == 0);
			default: seg_ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((wp_valid && wp_ready) || (seg_valid && seg_ready) || cfg_write)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic cfg_set(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic send_wp(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
			input logic f, input logic l);
		@(negedge clk);
		x_pos = x;
		y_pos = y;
		z_pos = z;
		first_point = f;
		last_point = l;
		wp_valid = 1'b1;
		do @(posedge clk); while (!wp_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			wp_valid = 1'b0;
			repeat ($urandom_range(0, 12)) @(negedge clk);
			burst_left = $urandom_range(0, 20);
		end
	endtask

	task automatic drain;
		@(negedge clk);
		wp_valid = 1'b0;
		while (segs_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] near_coord(input logic [31:0] base);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return base + $urandom_range(0, 32'hFFFF) - 32'h8000;
			3: return base + $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000;
			default: return base + $urandom_range(0, 32'h7FF_FFFF) - 32'h400_0000;
		endcase
	endfunction

	task automatic random_run(input int n);
		logic f, l;
		for (int i = 0; i < n; i++) begin
			f = ($urandom_range(0, 11) == 0);
			l = ($urandom_range(0, 13) == 0);
			bx = near_coord(bx);
			by = near_coord(by);
			bz = near_coord(bz);
			send_wp(bx, by, bz, f, l);
		end
	endtask

	function automatic logic [31:0] pick_rate;
		case ($urandom_range(0, 4))
			0: return 32'd1;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(32'h100, 32'h10_0000);
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = wsta_pkg::REG_MAX_VEL;
		cfg_data = '0;
		wp_valid = 1'b0;
		x_pos = '0;
		y_pos = '0;
		z_pos = '0;
		first_point = 1'b0;
		last_point = 1'b0;
		burst_left = 3;
		bx = '0;
		by = '0;
		bz = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, path starts and ends, extreme distances
		send_wp(32'd0, 32'd0, 32'd0, 1'b0, 1'b0);          // no previous point
		send_wp(32'd0, 32'd0, 32'd0, 1'b0, 1'b0);          // zero distance
		send_wp(32'h0001_0000, 32'd0, 32'd0, 1'b0, 1'b0);
		send_wp(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
		send_wp(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1);
		send_wp(32'hFFFF_FFFF, 32'd5, 32'd9, 1'b1, 1'b0);
		send_wp(32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000, 1'b0, 1'b0);
		send_wp(32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000, 1'b1, 1'b1);
		send_wp(32'd7, 32'd7, 32'd7, 1'b0, 1'b1);          // lone last point
		drain();
		cfg_set(wsta_pkg::REG_MODE, wsta_pkg::MODE_ACC);
		cfg_set(wsta_pkg::REG_MIN_TIME, 32'd0);
		send_wp(32'd0, 32'd0, 32'd0, 1'b1, 1'b0);
		send_wp(32'h0003_0000, 32'h0004_0000, 32'd0, 1'b0, 1'b0);
		send_wp(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b0, 1'b0);
		drain();
		cfg_set(wsta_pkg::REG_MODE, MODE_CONST);
		cfg_set(wsta_pkg::REG_MAX_VEL, 32'd1);
		send_wp(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
		send_wp(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
		drain();
		cfg_set(wsta_pkg::REG_MODE, MODE_SPARE);
		cfg_set(wsta_pkg::REG_MAX_VEL, 32'hFFFF_FFFF);
		cfg_set(wsta_pkg::REG_MIN_TIME, 32'hFFFF_FFFF);
		send_wp(32'd1, 32'd2, 32'd3, 1'b0, 1'b0);
		drain();
		// zero divisors
		cfg_set(wsta_pkg::REG_MAX_VEL, 32'd0);
		cfg_set(wsta_pkg::REG_MIN_TIME, 32'd100);
		send_wp(32'd10, 32'd2, 32'd3, 1'b0, 1'b0);
		drain();
		cfg_set(wsta_pkg::REG_MODE, wsta_pkg::MODE_SYM);
		cfg_set(wsta_pkg::REG_MAX_VEL, 32'h0004_0000);
		cfg_set(wsta_pkg::REG_MAX_ACC, 32'd0);
		send_wp(32'd20, 32'd2, 32'd3, 1'b0, 1'b0);
		drain();
		cfg_set(wsta_pkg::REG_MAX_ACC, 32'hFFFF_FFFF);
		send_wp(32'h0100_0000, 32'd2, 32'd3, 1'b0, 1'b1);
		drain();

		// random phases over settings
		for (int ph = 0; ph < 12; ph++) begin
			cfg_set(wsta_pkg::REG_MODE, 2'(ph % 4));
			cfg_set(wsta_pkg::REG_MAX_VEL, pick_rate());
			cfg_set(wsta_pkg::REG_MAX_ACC, pick_rate());
			case ($urandom_range(0, 3))
				0: cfg_set(wsta_pkg::REG_MIN_TIME, 32'd0);
				1: cfg_set(wsta_pkg::REG_MIN_TIME, $urandom);
				default: cfg_set(wsta_pkg::REG_MIN_TIME, $urandom_range(0, 32'h4_0000));
			endcase
			random_run(130);
			drain();
		end

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
design/wsta_pkg.sv
design/wsta_dp.sv
design/wsta_ctrl.sv
design/waypoint_segment_time_allocator.sv
tb/sv/wsta_segment_checker.sv
tb/sv/tb_waypoint_segment_time_allocator.sv
